### hw/rtl/lttvd_pkg.sv
// ----------------------------------------------------------------------------
// lttvd_pkg: shared types and constants
// Status codes, band coefficients and the request record passed from the
// front end to the divider back end.
// ----------------------------------------------------------------------------
`default_nettype none
package lttvd_pkg;

	// result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_ZSPD = 2'd2;
	localparam logic [1:0] ST_SAT  = 2'd3;

	// speed thresholds, Q8.8 m/s
	localparam logic [15:0] SPD_5  = 16'd1280;
	localparam logic [15:0] SPD_7  = 16'd1792;
	localparam logic [15:0] SPD_9  = 16'd2304;
	localparam logic [15:0] SPD_11 = 16'd2816;
	localparam logic [15:0] SPD_13 = 16'd3328;
	localparam logic [15:0] SPD_16 = 16'd4096;
	localparam logic [15:0] SPD_18 = 16'd4608;
	localparam logic [15:0] SPD_22 = 16'd5632;
	localparam logic [15:0] SPD_26 = 16'd6656;

	// band coefficient K = num / den
	typedef struct packed {
		logic [6:0]  num;
		logic [19:0] den;
	} band_t;

	// front to back record: numerator, denominator, status class
	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] numer;
		logic [39:0] denom;
	} lttvd_req_t;

	function automatic band_t mk_band(input logic [6:0] n, input logic [19:0] d);
		band_t b;
		b.num = n;
		b.den = d;
		return b;
	endfunction

	// band lookup from priority (class = -priority) and speed
	function automatic band_t pick_band(input logic signed [7:0] prio,
		input logic [15:0] s);
		band_t b;
		b = mk_band(7'd1, 20'd3840);
		if (prio == 8'sd0 || prio == -8'sd1) begin
			b = mk_band(7'd1, 20'd20800);
		end else if (prio == -8'sd2) begin
			if (s <= SPD_11)      b = mk_band(7'd125, 20'd799998);
			else if (s <= SPD_16) b = mk_band(7'd1, 20'd12000);
			else                  b = mk_band(7'd1, 20'd20800);
		end else if (prio == -8'sd3) begin
			if (s <= SPD_11)      b = mk_band(7'd1, 20'd3840);
			else if (s <= SPD_13) b = mk_band(7'd1, 20'd4200);
			else if (s <= SPD_16) b = mk_band(7'd17, 20'd120000);
			else                  b = mk_band(7'd1, 20'd18720);
		end else if (prio <= -8'sd4 || prio == 8'sd1) begin
			if (s <= SPD_5)       b = mk_band(7'd3, 20'd1600);
			else if (s <= SPD_7)  b = mk_band(7'd1, 20'd1100);
			else if (s <= SPD_9)  b = mk_band(7'd1, 20'd2560);
			else if (s <= SPD_11) b = mk_band(7'd1, 20'd3840);
			else if (s <= SPD_13) b = mk_band(7'd1, 20'd5400);
			else if (s <= SPD_16) b = mk_band(7'd17, 20'd126640);
			else if (s <= SPD_18) b = mk_band(7'd1, 20'd8800);
			else if (s <= SPD_22) b = mk_band(7'd1, 20'd9600);
			else if (s <= SPD_26) b = mk_band(7'd1, 20'd10400);
			else                  b = mk_band(7'd1, 20'd11200);
		end
		return b;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/lttvd_in_if.sv
// ----------------------------------------------------------------------------
// lttvd_in_if: link request channel
// Valid/ready channel carrying the attributes of one road link.
// ----------------------------------------------------------------------------
`default_nettype none
interface lttvd_in_if;
	logic              valid;
	logic              ready;
	logic              is_district;
	logic signed [7:0] road_priority;
	logic [3:0]        lane_count;
	logic [15:0]       link_speed;
	logic [23:0]       link_length;
	logic [23:0]       flow_rate;

	modport source(output valid, is_district, road_priority, lane_count,
		link_speed, link_length, flow_rate, input ready);
	modport sink(input valid, is_district, road_priority, lane_count,
		link_speed, link_length, flow_rate, output ready);
endinterface
`default_nettype wire

### hw/rtl/lttvd_out_if.sv
// ----------------------------------------------------------------------------
// lttvd_out_if: travel time result channel
// Valid/ready channel carrying the loaded travel time and its status.
// ----------------------------------------------------------------------------
`default_nettype none
interface lttvd_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] travel_time;
	logic [1:0]  status;

	modport source(output valid, travel_time, status, input ready);
	modport sink(input valid, travel_time, status, output ready);
endinterface
`default_nettype wire

### hw/rtl/link_travel_time_volume_delay.sv
// ----------------------------------------------------------------------------
// link_travel_time_volume_delay: loaded link travel time
// Volume-delay evaluation of one road link per request, with a front end,
// a decoupling queue and a pipelined divider back end.
// ----------------------------------------------------------------------------
// One link request is accepted every cycle unless a full queue blocks the
// front end; each result passes 38 registers after its request is accepted
// (4 front stages, 1 queue register, an entry stage plus 32 quotient stages
// ending in the result register), most of them in the 32-stage quotient
// divider. A stalled result stalls the divider only; the front end keeps
// accepting until the FIFO_DEPTH-entry queue fills.
`default_nettype none
module link_travel_time_volume_delay #(
	parameter int FIFO_DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	lttvd_in_if.sink  link,
	lttvd_out_if.source result
);
	import lttvd_pkg::*;

	logic       q_push, q_full, q_pop, q_nempty;
	lttvd_req_t q_wdata, q_rdata;

	lttvd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.link   (link),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_wdata)
	);

	lttvd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.nempty (q_nempty),
		.rdata  (q_rdata)
	);

	lttvd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_nempty (q_nempty),
		.q_data   (q_rdata),
		.q_pop    (q_pop),
		.res      (result)
	);

	// queue is never pushed while full nor popped while empty
	a_push_ok: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("push into full queue");
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_nempty) else $error("pop from empty queue");
	// zero-cost links read as zero, error results as all ones
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status == ST_ZERO) |-> result.travel_time == '0)
		else $error("zero-cost result not zero");
	a_ones: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.status == ST_ZSPD || result.status == ST_SAT))
		|-> result.travel_time == '1) else $error("error result not all ones");
endmodule
`default_nettype wire

### hw/rtl/lttvd_front.sv
// ----------------------------------------------------------------------------
// lttvd_front: classify and multiply
// Picks the band and special case of each link, then forms the numerator
// L*256*(den*lanes + num*F) and denominator S*den*lanes over four stages.
// ----------------------------------------------------------------------------
`default_nettype none
module lttvd_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	lttvd_in_if.sink               link,
	input  wire logic              q_full,
	output logic                   q_push,
	output lttvd_pkg::lttvd_req_t  q_data
);
	import lttvd_pkg::*;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic        adv;

	logic [1:0]  kind_s1, kind_s2, kind_s3;
	band_t       band_s1;
	logic [3:0]  lanes_s1;
	logic [15:0] spd_s1, spd_s2;
	logic [23:0] len_s1, len_s2, len_s3;
	logic [23:0] flow_s1;
	logic [23:0] dl_s2;
	logic [30:0] nf_s2;
	logic [31:0] sum_s3;
	logic [39:0] denom_s3;
	lttvd_req_t  req_s4;

	// whole pipe moves unless its tail is blocked by a full queue
	assign adv        = !v_s4 || !q_full;
	assign link.ready = adv;
	assign q_push     = v_s4 && !q_full;
	assign q_data     = req_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= link.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 1: special cases and band
			if (link.is_district || link.lane_count == 4'd0) kind_s1 <= ST_ZERO;
			else if (link.link_speed == 16'd0)               kind_s1 <= ST_ZSPD;
			else                                             kind_s1 <= ST_OK;
			band_s1  <= pick_band(link.road_priority, link.link_speed);
			lanes_s1 <= link.lane_count;
			spd_s1   <= link.link_speed;
			len_s1   <= link.link_length;
			flow_s1  <= link.flow_rate;
			// stage 2: den*lanes and num*flow
			kind_s2  <= kind_s1;
			dl_s2    <= band_s1.den * lanes_s1;
			nf_s2    <= band_s1.num * flow_s1;
			spd_s2   <= spd_s1;
			len_s2   <= len_s1;
			// stage 3: sum and denominator
			kind_s3  <= kind_s2;
			sum_s3   <= {8'd0, dl_s2} + {1'b0, nf_s2};
			denom_s3 <= spd_s2 * dl_s2;
			len_s3   <= len_s2;
			// stage 4: numerator, scaled by 256 (full 56-bit product)
			req_s4.kind  <= kind_s3;
			req_s4.numer <= {56'(len_s3) * 56'(sum_s3), 8'd0};
			req_s4.denom <= denom_s3;
		end
	end
endmodule
`default_nettype wire

### hw/rtl/lttvd_fifo.sv
// ----------------------------------------------------------------------------
// lttvd_fifo: decoupling queue
// Small register queue between the front end and the divider back end.
// ----------------------------------------------------------------------------
`default_nettype none
module lttvd_fifo #(
	parameter int DEPTH = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire lttvd_pkg::lttvd_req_t wdata,
	output logic                       full,
	input  wire logic                  pop,
	output logic                       nempty,
	output lttvd_pkg::lttvd_req_t      rdata
);
	import lttvd_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	lttvd_req_t      mem_q [DEPTH];
	logic [PW-1:0]   wp_q, rp_q;
	logic [CW-1:0]   cnt_q;

	assign full   = cnt_q == CW'(DEPTH);
	assign nempty = cnt_q != '0;
	assign rdata  = mem_q[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end
endmodule
`default_nettype wire

### hw/rtl/lttvd_back.sv
// ----------------------------------------------------------------------------
// lttvd_back: pipelined divider
// Overflow check, then one restoring quotient bit per stage over 32 stages,
// ending in the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module lttvd_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_nempty,
	input  wire lttvd_pkg::lttvd_req_t q_data,
	output logic                       q_pop,
	lttvd_out_if.source                res
);
	import lttvd_pkg::*;

	localparam int NS = 32;

	logic        v_q   [NS+1];
	logic [1:0]  st_q  [NS+1];
	logic [39:0] rem_q [NS+1];
	logic [31:0] low_q [NS+1];
	logic [31:0] quo_q [NS+1];
	logic [39:0] den_q [NS+1];
	logic        adv;

	assign adv   = !v_q[NS] || res.ready;
	assign q_pop = adv && q_nempty;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= NS; i++) v_q[i] <= 1'b0;
		end else if (adv) begin
			v_q[0] <= q_nempty;
			for (int i = 1; i <= NS; i++) v_q[i] <= v_q[i-1];
		end
	end

	// entry stage: quotient overflows 32 bits when N / 2^32 >= D
	always_ff @(posedge clk) begin
		if (adv) begin
			if (q_data.kind == ST_OK && {8'd0, q_data.numer[63:32]} >= q_data.denom)
				st_q[0] <= ST_SAT;
			else
				st_q[0] <= q_data.kind;
			rem_q[0] <= {8'd0, q_data.numer[63:32]};
			low_q[0] <= q_data.numer[31:0];
			quo_q[0] <= '0;
			den_q[0] <= q_data.denom;
		end
	end

	// one quotient bit per stage
	for (genvar k = 1; k <= NS; k++) begin : g_div
		logic [40:0] trial;
		logic        ge;
		assign trial = {rem_q[k-1], low_q[k-1][31]};
		assign ge    = trial >= {1'b0, den_q[k-1]};
		always_ff @(posedge clk) begin
			if (adv) begin
				st_q[k]  <= st_q[k-1];
				rem_q[k] <= ge ? 40'(trial - {1'b0, den_q[k-1]}) : trial[39:0];
				low_q[k] <= {low_q[k-1][30:0], 1'b0};
				quo_q[k] <= {quo_q[k-1][30:0], ge};
				den_q[k] <= den_q[k-1];
			end
		end
	end

	// result mapping
	assign res.valid  = v_q[NS];
	assign res.status = st_q[NS];
	always_comb begin
		case (st_q[NS])
			ST_OK:   res.travel_time = quo_q[NS];
			ST_ZERO: res.travel_time = '0;
			default: res.travel_time = '1;
		endcase
	end
endmodule
`default_nettype wire
